// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the button press classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge while out of reset.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("%m: property failed");
// Check that a condition never holds on a rising edge while out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("%m: forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== rtl/mbpc_pkg.sv =====
// Types, constants and codes shared by the button press classifier modules.
package mbpc_pkg;

	localparam int NUM_BUTTONS = 7;
	localparam int COUNT_WIDTH = 16;
	localparam int THR_WIDTH   = 16;
	localparam int FIELD_WIDTH = 7;
	localparam int CMP_WIDTH   = (COUNT_WIDTH > THR_WIDTH) ? COUNT_WIDTH : THR_WIDTH;

	typedef logic [NUM_BUTTONS-1:0] btn_vec_t;
	typedef logic [FIELD_WIDTH-1:0] field_t;
	typedef logic [COUNT_WIDTH-1:0] cnt_t;
	typedef logic [THR_WIDTH-1:0]   thr_t;
	typedef logic                   reg_idx_t;

	localparam cnt_t CNT_MAX = '1;

	// Press phase codes; the fourth code is treated as idle.
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_SHORT = 2'd1;
	localparam logic [1:0] PH_LONG  = 2'd2;

	// Register indexes of the configuration port.
	localparam reg_idx_t REG_SHORT_THR = 1'b0;
	localparam reg_idx_t REG_LONG_THR  = 1'b1;

	localparam thr_t SHORT_THR_RST = THR_WIDTH'(25);
	localparam thr_t LONG_THR_RST  = THR_WIDTH'(120);

	// Shared command from the merge stage to every lane.
	typedef struct packed {
		logic update;
		logic clear;
	} lane_ctrl_t;

	// What one lane found for the current item.
	typedef struct packed {
		logic short_hit;
		logic long_hit;
	} lane_report_t;

	// All lanes' findings gathered for the merge stage.
	typedef struct packed {
		btn_vec_t short_hit;
		btn_vec_t long_hit;
	} lane_hits_t;

	typedef struct packed {
		field_t short_press;
		field_t long_press;
		logic   lockout;
	} result_t;

endpackage

// ===== rtl/mbpc_lane.sv =====
// One button lane: hold counter and press phase machine.
module mbpc_lane (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pressed,
	input  mbpc_pkg::thr_t        short_thr,
	input  mbpc_pkg::thr_t        long_thr,
	input  mbpc_pkg::lane_ctrl_t  ctrl,
	output mbpc_pkg::lane_report_t report
);
	import mbpc_pkg::*;

	logic [1:0] phase_q;
	logic [1:0] phase_d;
	cnt_t       count_q;
	cnt_t       count_d;
	cnt_t       count_inc;
	logic       over_short;
	logic       over_long;

	// Saturating increment, then compare against both thresholds.
	assign count_inc  = (count_q == CNT_MAX) ? count_q : count_q + COUNT_WIDTH'(1);
	assign over_short = CMP_WIDTH'(count_inc) > CMP_WIDTH'(short_thr);
	assign over_long  = CMP_WIDTH'(count_inc) > CMP_WIDTH'(long_thr);

	always_comb begin
		phase_d          = PH_IDLE;
		count_d          = count_inc;
		report.short_hit = 1'b0;
		report.long_hit  = 1'b0;
		unique case (phase_q)
			PH_SHORT: begin
				if (pressed) begin
					phase_d = over_long ? PH_LONG : PH_SHORT;
				end else begin
					count_d          = '0;
					report.short_hit = 1'b1;
				end
			end
			PH_LONG: begin
				if (pressed) begin
					phase_d = PH_LONG;
				end else begin
					count_d         = '0;
					report.long_hit = 1'b1;
				end
			end
			default: begin
				if (pressed) begin
					phase_d = over_short ? PH_SHORT : PH_IDLE;
				end else begin
					count_d = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
		end else if (ctrl.update) begin
			if (ctrl.clear) begin
				phase_q <= PH_IDLE;
				count_q <= '0;
			end else begin
				phase_q <= phase_d;
				count_q <= count_d;
			end
		end
	end

endmodule

// ===== rtl/mbpc_merge.sv =====
// Merge stage: lockout tracking, global machine clear and pulse gating.
module mbpc_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  mbpc_pkg::btn_vec_t   levels,
	input  mbpc_pkg::lane_hits_t hits,
	output mbpc_pkg::lane_ctrl_t ctrl,
	output mbpc_pkg::result_t    result
);
	import mbpc_pkg::*;

	logic lock_q;
	logic lock_d;
	logic multi;
	logic pulse_any;

	// Two or more pressed buttons leave a bit after dropping the lowest one.
	assign multi     = |(levels & (levels - NUM_BUTTONS'(1)));
	assign lock_d    = multi | (lock_q & (levels != '0));
	assign pulse_any = |(hits.short_hit | hits.long_hit);

	assign ctrl.update = accept;
	assign ctrl.clear  = lock_d | pulse_any;

	assign result.short_press = lock_d ? '0 : FIELD_WIDTH'(hits.short_hit);
	assign result.long_press  = lock_d ? '0 : FIELD_WIDTH'(hits.long_hit);
	assign result.lockout     = lock_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q <= 1'b0;
		end else if (accept) begin
			lock_q <= lock_d;
		end
	end

endmodule

// ===== rtl/multi_button_press_classifier.sv =====
// Top level of the multi-button short/long press classifier.
//   Input channel (in_valid / in_stall): one item per sample tick, carrying
//   the levels of all buttons in button_levels (bit i is button i, 1 pressed).
//   Output channel (out_valid / out_stall): exactly one result item per input
//   item, in order: short_press and long_press hold a one-item pulse for the
//   button released after a short or long hold, lockout is set while a
//   multi-button press lockout is active.
//   Configuration: cfg_wr_en writes cfg_wdata to the threshold selected by
//   cfg_index (0 short, 1 long) at the clock edge; write only while idle.
// Timing:
//   One item per cycle unless the receiver stalls; each result is registered in
//   the output register, or the skid register while the output is held. Every
//   lane updates its counter and phase in the accept cycle, and the merge stage
//   folds all lanes into the shared clear in that same cycle, so the next item can follow at once.
// Stall: an output register plus one skid register hold finished results;
//   in_stall rises only when both are full, so one more item is taken after
//   the receiver stalls.
// Reset: arst_n clears all phases, counters, the lockout flag and the output
//   queue, and loads thresholds of 25 and 120 ticks.
module multi_button_press_classifier (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  mbpc_pkg::field_t     button_levels,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mbpc_pkg::field_t     short_press,
	output mbpc_pkg::field_t     long_press,
	output logic                 lockout,
	input  logic                 cfg_wr_en,
	input  mbpc_pkg::reg_idx_t   cfg_index,
	input  mbpc_pkg::thr_t       cfg_wdata
);
	import mbpc_pkg::*;

	`include "assert_macros.svh"

	thr_t         short_thr_q;
	thr_t         long_thr_q;
	btn_vec_t     levels;
	logic         accept;
	lane_ctrl_t   ctrl;
	lane_hits_t   hits;
	lane_report_t reports [NUM_BUTTONS];
	result_t      result;
	result_t      out_q;
	result_t      skid_q;
	logic         out_valid_q;
	logic         skid_valid_q;
	logic         out_take;

	// Threshold registers; an index outside the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_thr_q <= SHORT_THR_RST;
			long_thr_q  <= LONG_THR_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SHORT_THR: short_thr_q <= cfg_wdata;
				REG_LONG_THR:  long_thr_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Take an item whenever the skid register is free.
	assign in_stall = skid_valid_q;
	assign accept   = in_valid & ~skid_valid_q;
	assign levels   = NUM_BUTTONS'(button_levels);

	// One lane per button, all driven by the shared merge command.
	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
		mbpc_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.pressed   (levels[i]),
			.short_thr (short_thr_q),
			.long_thr  (long_thr_q),
			.ctrl      (ctrl),
			.report    (reports[i])
		);
		assign hits.short_hit[i] = reports[i].short_hit;
		assign hits.long_hit[i]  = reports[i].long_hit;
	end

	// Fold lane findings into the lockout flag, the clear and the result item.
	mbpc_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.levels (levels),
		.hits   (hits),
		.ctrl   (ctrl),
		.result (result)
	);

	// Output register with a skid stage behind it.
	assign out_take = out_valid_q & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_take || !out_valid_q) begin
			// Refill the output register, draining the skid first.
			out_valid_q  <= skid_valid_q | accept;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			// Output held: park the new item in the skid register.
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : result;
		end
		if (accept && out_valid_q && !out_take) begin
			skid_q <= result;
		end
	end

	assign out_valid   = out_valid_q;
	assign short_press = out_q.short_press;
	assign long_press  = out_q.long_press;
	assign lockout     = out_q.lockout;

	`ASSERT_NEVER(a_skid_without_out, clk, arst_n, skid_valid_q && !out_valid_q)
	`ASSERT_NEVER(a_short_and_long, clk, arst_n, out_valid && |(short_press & long_press))
	`ASSERT_AT(a_one_pulse, clk, arst_n, out_valid |-> $onehot0({short_press, long_press}))
	`ASSERT_AT(a_lock_no_pulse, clk, arst_n, (out_valid && lockout) |-> ({short_press, long_press} == '0))
	`ASSERT_AT(a_lock_clears, clk, arst_n, (accept && result.lockout) |-> ctrl.clear)

endmodule
